// ===== hw/rtl/abf_pkg.sv =====
`default_nettype none
package abf_pkg;

  localparam int AXES       = 3;
  localparam int FRAC_BITS  = 16;
  localparam int AXIS_W     = 2;
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Multiplier operands are one bit wider than the data so that the residual
  // and the unsigned step both fit as signed values.
  localparam int OPND_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int QUO_W     = GAIN_W + OPND_W;
  localparam int SAT_W     = PROD_W + 2;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int PC_W      = 4;

  localparam logic [DATA_W-1:0] TSTEP_RESET = DATA_W'(6554);

  localparam logic signed [PROD_W-1:0] RND_HALF =
    {{(PROD_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_MUL_DT,
    OP_PRED,
    OP_RES,
    OP_MUL_A,
    OP_POS,
    OP_MUL_B,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_VEL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NEXT,
    CND_JUMP,
    CND_WAIT_IN,
    CND_BAD_AXIS,
    CND_DIV_LOOP,
    CND_WAIT_OUT
  } cond_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_TSTEP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic axis_bad;
    logic div_last;
  } status_t;

  typedef struct packed {
    logic [GAIN_W-1:0] alpha;
    logic [GAIN_W-1:0] beta;
    logic [DATA_W-1:0] tstep;
  } cfg_t;

  localparam pc_t PC_ACCEPT   = PC_W'(0);
  localparam pc_t PC_LOAD     = PC_W'(1);
  localparam pc_t PC_MUL_DT   = PC_W'(2);
  localparam pc_t PC_PRED     = PC_W'(3);
  localparam pc_t PC_RES      = PC_W'(4);
  localparam pc_t PC_MUL_A    = PC_W'(5);
  localparam pc_t PC_POS      = PC_W'(6);
  localparam pc_t PC_MUL_B    = PC_W'(7);
  localparam pc_t PC_DIV_INIT = PC_W'(8);
  localparam pc_t PC_DIV_STEP = PC_W'(9);
  localparam pc_t PC_VEL      = PC_W'(10);
  localparam pc_t PC_EMIT     = PC_W'(11);

  // Microprogram ROM. Unused addresses jump back to the accept step.
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t w;
    w.op     = OP_NOP;
    w.cond   = CND_JUMP;
    w.target = PC_ACCEPT;
    unique case (pc)
      PC_ACCEPT: begin
        w.op   = OP_ACCEPT;
        w.cond = CND_WAIT_IN;
      end
      PC_LOAD: begin
        w.op     = OP_LOAD;
        w.cond   = CND_BAD_AXIS;
        w.target = PC_EMIT;
      end
      PC_MUL_DT: begin
        w.op   = OP_MUL_DT;
        w.cond = CND_NEXT;
      end
      PC_PRED: begin
        w.op   = OP_PRED;
        w.cond = CND_NEXT;
      end
      PC_RES: begin
        w.op   = OP_RES;
        w.cond = CND_NEXT;
      end
      PC_MUL_A: begin
        w.op   = OP_MUL_A;
        w.cond = CND_NEXT;
      end
      PC_POS: begin
        w.op   = OP_POS;
        w.cond = CND_NEXT;
      end
      PC_MUL_B: begin
        w.op   = OP_MUL_B;
        w.cond = CND_NEXT;
      end
      PC_DIV_INIT: begin
        w.op   = OP_DIV_INIT;
        w.cond = CND_NEXT;
      end
      PC_DIV_STEP: begin
        w.op     = OP_DIV_STEP;
        w.cond   = CND_DIV_LOOP;
        w.target = PC_DIV_STEP;
      end
      PC_VEL: begin
        w.op   = OP_VEL;
        w.cond = CND_NEXT;
      end
      PC_EMIT: begin
        w.op     = OP_EMIT;
        w.cond   = CND_WAIT_OUT;
        w.target = PC_ACCEPT;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Clamp a wide signed value to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-DATA_W:0] hi;
    hi = x[SAT_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_W-1]) begin
      return {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W - 1){1'b1}}};
    end
  endfunction

  // Drop the fraction bits, rounding half up.
  function automatic logic signed [PROD_W-1:0] round_shift(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + RND_HALF;
    return s >>> FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/abf_in_if.sv =====
`default_nettype none
interface abf_in_if;
  logic                              valid;
  logic                              ready;
  logic [abf_pkg::AXIS_W-1:0]        axis;
  logic signed [abf_pkg::DATA_W-1:0] sample;

  modport source (output valid, output axis, output sample, input ready);
  modport sink (input valid, input axis, input sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/abf_out_if.sv =====
`default_nettype none
interface abf_out_if;
  logic                              valid;
  logic                              ready;
  logic [abf_pkg::AXIS_W-1:0]        axis_out;
  logic signed [abf_pkg::DATA_W-1:0] position_estimate;

  modport source (output valid, output axis_out, output position_estimate, input ready);
  modport sink (input valid, input axis_out, input position_estimate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/abf_cfg_if.sv =====
`default_nettype none
interface abf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [abf_pkg::CFG_IDX_W-1:0]     index;
  logic [abf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/abf_dp.sv =====
`default_nettype none
module abf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  abf_pkg::ctl_t                     ctl,
  input  abf_pkg::cfg_t                     cfg,
  input  logic                              in_take,
  input  logic [abf_pkg::AXIS_W-1:0]        in_axis,
  input  logic signed [abf_pkg::DATA_W-1:0] in_sample,
  output abf_pkg::status_t                  st,
  output logic [abf_pkg::AXIS_W-1:0]        res_axis,
  output logic signed [abf_pkg::DATA_W-1:0] res_pos
);

  logic [abf_pkg::AXIS_W-1:0]         axis_r;
  logic signed [abf_pkg::DATA_W-1:0]  sample_r;
  logic signed [abf_pkg::DATA_W-1:0]  pos_r;
  logic signed [abf_pkg::DATA_W-1:0]  vel_r;
  logic signed [abf_pkg::DATA_W-1:0]  pred_r;
  logic signed [abf_pkg::OPND_W-1:0]  res_r;
  logic signed [abf_pkg::PROD_W-1:0]  prod_r;
  logic [abf_pkg::QUO_W-1:0]          quo_r;
  logic [abf_pkg::DATA_W-1:0]         rem_r;
  logic                               neg_r;
  logic [abf_pkg::DIV_CNT_W-1:0]      cnt_r;

  logic signed [abf_pkg::DATA_W-1:0]  pos_store_r [abf_pkg::AXES];
  logic signed [abf_pkg::DATA_W-1:0]  vel_store_r [abf_pkg::AXES];

  logic signed [abf_pkg::OPND_W-1:0]  mul_a;
  logic signed [abf_pkg::OPND_W-1:0]  mul_b;
  logic signed [abf_pkg::PROD_W-1:0]  prod_nxt;
  logic signed [abf_pkg::PROD_W-1:0]  rnd;
  logic signed [abf_pkg::DATA_W-1:0]  pred_nxt;
  logic signed [abf_pkg::OPND_W-1:0]  res_nxt;
  logic signed [abf_pkg::DATA_W-1:0]  pos_nxt;
  logic signed [abf_pkg::DATA_W-1:0]  vel_nxt;
  logic [abf_pkg::PROD_W-1:0]         prod_abs;
  logic [abf_pkg::DATA_W-1:0]         divisor;
  logic [abf_pkg::DATA_W:0]           shifted;
  logic [abf_pkg::DATA_W:0]           trial;
  logic                               fits;
  logic [abf_pkg::DATA_W-1:0]         rem_nxt;
  logic [abf_pkg::QUO_W:0]            quo_mag;
  logic signed [abf_pkg::QUO_W:0]     quo_signed;

  // One shared multiplier; the operands follow the current micro-op.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.op)
      abf_pkg::OP_MUL_DT: begin
        mul_a = {1'b0, cfg.tstep};
        mul_b = abf_pkg::OPND_W'(vel_r);
      end
      abf_pkg::OP_MUL_A: begin
        mul_a = abf_pkg::OPND_W'(cfg.alpha);
        mul_b = res_r;
      end
      abf_pkg::OP_MUL_B: begin
        mul_a = abf_pkg::OPND_W'(cfg.beta);
        mul_b = res_r;
      end
      default: ;
    endcase
  end

  assign prod_nxt = abf_pkg::PROD_W'(mul_a) * abf_pkg::PROD_W'(mul_b);
  assign rnd      = abf_pkg::round_shift(prod_r);
  assign pred_nxt = abf_pkg::sat_data(abf_pkg::SAT_W'(pos_r) + abf_pkg::SAT_W'(rnd));
  assign res_nxt  = abf_pkg::OPND_W'(sample_r) - abf_pkg::OPND_W'(pred_r);
  assign pos_nxt  = abf_pkg::sat_data(abf_pkg::SAT_W'(pred_r) + abf_pkg::SAT_W'(rnd));

  // Restoring division of |beta*r| by dt, one quotient bit per step.
  // A zero step divides by one LSB.
  assign divisor  = (cfg.tstep == '0) ? abf_pkg::DATA_W'(1) : cfg.tstep;
  assign prod_abs = prod_r[abf_pkg::PROD_W-1] ? -prod_r : prod_r;
  assign shifted  = {rem_r, quo_r[abf_pkg::QUO_W-1]};
  assign fits     = shifted >= {1'b0, divisor};
  assign trial    = shifted - {1'b0, divisor};
  assign rem_nxt  = fits ? trial[abf_pkg::DATA_W-1:0] : shifted[abf_pkg::DATA_W-1:0];

  assign quo_mag    = {1'b0, quo_r};
  assign quo_signed = neg_r ? -$signed(quo_mag) : $signed(quo_mag);
  assign vel_nxt    = abf_pkg::sat_data(abf_pkg::SAT_W'(vel_r) + abf_pkg::SAT_W'(quo_signed));

  assign st.axis_bad = int'(axis_r) >= abf_pkg::AXES;
  assign st.div_last = (cnt_r == '0);

  assign res_axis = axis_r;
  assign res_pos  = pos_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      axis_r   <= in_axis;
      sample_r <= in_sample;
    end
    unique case (ctl.op)
      abf_pkg::OP_LOAD: begin
        if (st.axis_bad) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_store_r[axis_r];
          vel_r <= vel_store_r[axis_r];
        end
      end
      abf_pkg::OP_MUL_DT, abf_pkg::OP_MUL_A, abf_pkg::OP_MUL_B: begin
        prod_r <= prod_nxt;
      end
      abf_pkg::OP_PRED: begin
        pred_r <= pred_nxt;
      end
      abf_pkg::OP_RES: begin
        res_r <= res_nxt;
      end
      abf_pkg::OP_POS: begin
        pos_r <= pos_nxt;
      end
      abf_pkg::OP_DIV_INIT: begin
        quo_r <= prod_abs[abf_pkg::QUO_W-1:0];
        rem_r <= '0;
        neg_r <= prod_r[abf_pkg::PROD_W-1];
        cnt_r <= abf_pkg::DIV_CNT_W'(abf_pkg::QUO_W - 1);
      end
      abf_pkg::OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[abf_pkg::QUO_W-2:0], fits};
        cnt_r <= cnt_r - abf_pkg::DIV_CNT_W'(1);
      end
      abf_pkg::OP_VEL: begin
        vel_r <= vel_nxt;
      end
      default: ;
    endcase
  end

  // The write-back step is only reached for a valid axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < abf_pkg::AXES; i++) begin
        pos_store_r[i] <= '0;
        vel_store_r[i] <= '0;
      end
    end else if (ctl.op == abf_pkg::OP_VEL) begin
      pos_store_r[axis_r] <= pos_r;
      vel_store_r[axis_r] <= vel_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/three_axis_alpha_beta_filter.sv =====
`default_nettype none
// Alpha-beta tracking filter for three axes, signed Q16.16.
// in_ch carries one request per sample: an axis number and the measured value.
// out_ch returns one request per input: the axis and the saturated new position.
// cfg_ch writes alpha (index 0), beta (index 1) and the step dt (index 2); it is
// always ready and should only be written while no sample is in flight.
// A small microprogram drives a shared 33x33 multiplier and a restoring divider.
// One sample is in flight at a time: a new input is taken only after the result of
// the last one has gone to the output register. Most of the work is the 50-step
// division of beta*residual by dt, one quotient bit a cycle.
// A sample for an axis number of 3 skips from the load step to the emit step,
// changes no per-axis state and returns a zero position.
// Reset (synchronous, rst_n low) clears the per-axis position and velocity, sets
// both gains to zero and dt to 6554 (about 0.1), and empties the output register.
// When out_ch stalls, the result waits in the output register. The next request is
// still taken and computed, and the sequencer then holds at its emit step until the
// output register is free again.
module three_axis_alpha_beta_filter (
  input  logic       clk,
  input  logic       rst_n,
  abf_in_if.sink     in_ch,
  abf_out_if.source  out_ch,
  abf_cfg_if.sink    cfg_ch
);

  abf_pkg::pc_t                      pc_r;
  abf_pkg::pc_t                      pc_nxt;
  abf_pkg::ctl_t                     ctl;
  abf_pkg::status_t                  st;
  abf_pkg::cfg_t                     cfg_r;
  logic                              in_take;
  logic                              out_free;
  logic                              emit_fire;
  logic                              out_valid_r;
  logic [abf_pkg::AXIS_W-1:0]        out_axis_r;
  logic signed [abf_pkg::DATA_W-1:0] out_pos_r;
  logic [abf_pkg::AXIS_W-1:0]        res_axis;
  logic signed [abf_pkg::DATA_W-1:0] res_pos;

  assign ctl       = abf_pkg::ucode(pc_r);
  assign in_take   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_fire = (ctl.op == abf_pkg::OP_EMIT) && out_free;

  assign in_ch.ready  = (ctl.op == abf_pkg::OP_ACCEPT);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.axis_out          = out_axis_r;
  assign out_ch.position_estimate = out_pos_r;

  abf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .in_take   (in_take),
    .in_axis   (in_ch.axis),
    .in_sample (in_ch.sample),
    .st        (st),
    .res_axis  (res_axis),
    .res_pos   (res_pos)
  );

  always_comb begin
    pc_nxt = pc_r;
    unique case (ctl.cond)
      abf_pkg::CND_NEXT:     pc_nxt = pc_r + abf_pkg::PC_W'(1);
      abf_pkg::CND_JUMP:     pc_nxt = ctl.target;
      abf_pkg::CND_WAIT_IN:  pc_nxt = in_take ? pc_r + abf_pkg::PC_W'(1) : pc_r;
      abf_pkg::CND_BAD_AXIS: pc_nxt = st.axis_bad ? ctl.target : pc_r + abf_pkg::PC_W'(1);
      abf_pkg::CND_DIV_LOOP: pc_nxt = st.div_last ? pc_r + abf_pkg::PC_W'(1) : ctl.target;
      abf_pkg::CND_WAIT_OUT: pc_nxt = out_free ? ctl.target : pc_r;
      default:               pc_nxt = abf_pkg::PC_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= abf_pkg::PC_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha <= '0;
      cfg_r.beta  <= '0;
      cfg_r.tstep <= abf_pkg::TSTEP_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        abf_pkg::CFG_ALPHA: cfg_r.alpha <= cfg_ch.data[abf_pkg::GAIN_W-1:0];
        abf_pkg::CFG_BETA:  cfg_r.beta  <= cfg_ch.data[abf_pkg::GAIN_W-1:0];
        abf_pkg::CFG_TSTEP: cfg_r.tstep <= cfg_ch.data[abf_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_axis_r <= res_axis;
      out_pos_r  <= res_pos;
    end
  end

`ifndef ASSERT_OFF
  a_in_only_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (pc_r == abf_pkg::PC_ACCEPT))
    else $error("input request taken while the sequencer is busy");

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.op == abf_pkg::OP_EMIT))
    else $error("result appeared outside the emit step");

  a_div_loops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == abf_pkg::OP_DIV_STEP && !st.div_last) |=> (ctl.op == abf_pkg::OP_DIV_STEP))
    else $error("division left before its last step");

  a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (pc_r == abf_pkg::PC_ACCEPT && out_valid_r))
    else $error("emit did not hand over the result and return to accept");
`endif

endmodule
`default_nettype wire

// ===== dv/three_axis_alpha_beta_filter_tb.sv =====
`timescale 1ns / 1ps
module three_axis_alpha_beta_filter_tb;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 70;
  localparam int REPORT_LIMIT  = 10;
  localparam int WIDE_W        = 80;

  localparam logic [abf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [abf_pkg::AXIS_W-1:0]    AXIS_NONE = 2'd3;

  localparam logic [abf_pkg::GAIN_W-1:0] GAIN_ONE =
    abf_pkg::GAIN_W'(1 << abf_pkg::FRAC_BITS);
  localparam logic [abf_pkg::GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic signed [abf_pkg::DATA_W-1:0] DATA_MAX =
    {1'b0, {(abf_pkg::DATA_W - 1){1'b1}}};
  localparam logic signed [abf_pkg::DATA_W-1:0] DATA_MIN =
    {1'b1, {(abf_pkg::DATA_W - 1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(DATA_MAX);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(DATA_MIN);
  localparam logic signed [WIDE_W-1:0] HALF_LSB = WIDE_W'(1 << (abf_pkg::FRAC_BITS - 1));

  typedef struct packed {
    logic [abf_pkg::AXIS_W-1:0]        axis;
    logic signed [abf_pkg::DATA_W-1:0] position;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n;

  abf_in_if  in_ch ();
  abf_out_if out_ch ();
  abf_cfg_if cfg_ch ();

  three_axis_alpha_beta_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Expected filter state and register copies.
  logic [abf_pkg::GAIN_W-1:0]        alpha_q16;
  logic [abf_pkg::GAIN_W-1:0]        beta_q16;
  logic [abf_pkg::DATA_W-1:0]        dt_q16;
  logic signed [abf_pkg::DATA_W-1:0] pos_est [abf_pkg::AXES];
  logic signed [abf_pkg::DATA_W-1:0] vel_est [abf_pkg::AXES];

  estimate_t position_expect_q[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct;
  int        recv_idle_pct;

  always #CLK_HALF_NS clk = ~clk;

  function automatic logic signed [WIDE_W-1:0] clamp_data(input logic signed [WIDE_W-1:0] x);
    if (x > WIDE_MAX) begin
      return WIDE_MAX;
    end else if (x < WIDE_MIN) begin
      return WIDE_MIN;
    end
    return x;
  endfunction

  // Advances the tracked state of a valid axis and returns the new position, else zero.
  function automatic estimate_t track_axis(input logic [abf_pkg::AXIS_W-1:0] ax,
                                           input logic signed [abf_pkg::DATA_W-1:0] meas);
    estimate_t est;
    logic signed [WIDE_W-1:0] pos, vel, dt, pred, resid, corr, divisor, vel_step;
    est.axis     = ax;
    est.position = '0;
    if (ax >= abf_pkg::AXES) begin
      return est;
    end
    pos   = pos_est[ax];
    vel   = vel_est[ax];
    dt    = $signed(WIDE_W'(dt_q16));
    pred  = clamp_data(pos + ((dt * vel + HALF_LSB) >>> abf_pkg::FRAC_BITS));
    resid = meas - pred;
    corr  = ($signed(WIDE_W'(alpha_q16)) * resid + HALF_LSB) >>> abf_pkg::FRAC_BITS;
    pos   = clamp_data(pred + corr);
    // A zero step still predicts with zero but divides by one LSB.
    divisor = dt;
    if (dt_q16 == 0) begin
      divisor = 1;
    end
    vel_step    = ($signed(WIDE_W'(beta_q16)) * resid) / divisor;
    vel         = clamp_data(vel + vel_step);
    pos_est[ax] = pos[abf_pkg::DATA_W-1:0];
    vel_est[ax] = vel[abf_pkg::DATA_W-1:0];
    est.position = pos[abf_pkg::DATA_W-1:0];
    return est;
  endfunction

  task automatic send_sample(input logic [abf_pkg::AXIS_W-1:0] ax,
                             input logic signed [abf_pkg::DATA_W-1:0] meas);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(70, 1) : $urandom_range(4, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.axis   <= ax;
    in_ch.sample <= meas;
    do @(posedge clk); while (!in_ch.ready);
    position_expect_q.push_back(track_axis(ax, meas));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (position_expect_q.size() != 0) @(posedge clk);
  endtask

  // Registers only change while nothing is in flight.
  task automatic write_reg(input logic [abf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [abf_pkg::CFG_DATA_W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      abf_pkg::CFG_ALPHA: alpha_q16 = value[abf_pkg::GAIN_W-1:0];
      abf_pkg::CFG_BETA:  beta_q16 = value[abf_pkg::GAIN_W-1:0];
      abf_pkg::CFG_TSTEP: dt_q16 = value;
      default: ;
    endcase
  endtask

  function automatic logic [abf_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_ONE;
      2: return GAIN_MAX;
      3: return abf_pkg::GAIN_W'($urandom);
      default: return abf_pkg::GAIN_W'($urandom_range(GAIN_ONE));
    endcase
  endfunction

  task automatic program_random_gains();
    logic [abf_pkg::CFG_DATA_W-1:0] alpha_word, beta_word, dt_word;
    // Upper bits of the gain words are random; the block keeps only the gain width.
    alpha_word = $urandom;
    beta_word  = $urandom;
    alpha_word[abf_pkg::GAIN_W-1:0] = pick_gain();
    beta_word[abf_pkg::GAIN_W-1:0]  = pick_gain();
    case ($urandom_range(7))
      0: dt_word = '0;
      1: dt_word = 1;
      2: dt_word = '1;
      3: dt_word = abf_pkg::TSTEP_RESET;
      4: dt_word = $urandom;
      default: dt_word = $urandom_range(1 << (abf_pkg::FRAC_BITS + 1), 1);
    endcase
    write_reg(abf_pkg::CFG_ALPHA, alpha_word);
    write_reg(abf_pkg::CFG_BETA, beta_word);
    write_reg(abf_pkg::CFG_TSTEP, dt_word);
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_SPARE, $urandom);
    end
  endtask

  // Mostly smooth per-axis trajectories with a little noise; the rest are
  // jumps, full-range outliers and requests for the missing axis.
  task automatic run_tracking(input int count);
    logic signed [abf_pkg::DATA_W-1:0] course [abf_pkg::AXES];
    logic signed [abf_pkg::DATA_W-1:0] slope [abf_pkg::AXES];
    logic [abf_pkg::AXIS_W-1:0]        ax;
    logic signed [abf_pkg::DATA_W-1:0] meas;
    int                                pick;
    for (int i = 0; i < abf_pkg::AXES; i++) begin
      course[i] = $urandom;
      course[i] = course[i] >>> 6;
      slope[i]  = $urandom;
      slope[i]  = slope[i] >>> 14;
    end
    repeat (count) begin
      pick = $urandom_range(99);
      ax   = abf_pkg::AXIS_W'($urandom_range(abf_pkg::AXES - 1));
      if (pick < 5) begin
        ax   = AXIS_NONE;
        meas = $urandom;
      end else if (pick < 15) begin
        meas = $urandom;
      end else begin
        if (pick < 18) begin
          course[ax] = $urandom;
        end
        course[ax] = course[ax] + slope[ax];
        meas = course[ax] + abf_pkg::DATA_W'($urandom_range(512)) - abf_pkg::DATA_W'(256);
      end
      send_sample(ax, meas);
    end
  endtask

  task automatic test_reset_state();
    // Both gains are zero after reset, so every estimate stays at zero.
    send_sample(0, DATA_MAX);
    send_sample(1, DATA_MIN);
    send_sample(AXIS_NONE, $urandom);
  endtask

  task automatic test_unit_gains();
    write_reg(abf_pkg::CFG_ALPHA, abf_pkg::CFG_DATA_W'(GAIN_ONE));
    write_reg(abf_pkg::CFG_BETA, abf_pkg::CFG_DATA_W'(GAIN_ONE));
    write_reg(abf_pkg::CFG_TSTEP, 1 << abf_pkg::FRAC_BITS);
    send_sample(0, DATA_MAX);
    send_sample(0, DATA_MIN);
    send_sample(1, DATA_MIN);
    send_sample(1, DATA_MAX);
    send_sample(2, 0);
    send_sample(2, -1);
    send_sample(AXIS_NONE, -1);
  endtask

  task automatic test_gains_above_one();
    write_reg(abf_pkg::CFG_ALPHA, abf_pkg::CFG_DATA_W'(GAIN_MAX));
    write_reg(abf_pkg::CFG_BETA, abf_pkg::CFG_DATA_W'(GAIN_MAX));
    send_sample(0, DATA_MAX);
    send_sample(1, DATA_MIN);
    send_sample(2, 12345 << abf_pkg::FRAC_BITS);
    send_sample(0, DATA_MIN);
  endtask

  task automatic test_zero_time_step();
    write_reg(abf_pkg::CFG_TSTEP, 0);
    send_sample(0, 1 << abf_pkg::FRAC_BITS);
    send_sample(0, 1 << abf_pkg::FRAC_BITS);
    send_sample(1, -(1 << abf_pkg::FRAC_BITS));
    send_sample(2, DATA_MAX);
  endtask

  task automatic test_time_step_extremes();
    write_reg(abf_pkg::CFG_TSTEP, 1);
    send_sample(0, $urandom);
    send_sample(1, DATA_MAX);
    write_reg(abf_pkg::CFG_TSTEP, '1);
    send_sample(0, DATA_MIN);
    send_sample(2, DATA_MAX);
    send_sample(1, 0);
  endtask

  task automatic test_unknown_register();
    write_reg(CFG_SPARE, '1);
    send_sample(0, $urandom);
    send_sample(1, $urandom);
    send_sample(2, $urandom);
  endtask

  task automatic test_random_tracking();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        program_random_gains();
        run_tracking(100);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    estimate_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (position_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: axis %0d position %0d",
                   out_ch.axis_out, out_ch.position_estimate);
        end
      end else begin
        want = position_expect_q.pop_front();
        if (out_ch.axis_out !== want.axis || out_ch.position_estimate !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("position mismatch: expected axis %0d position %0d, got axis %0d position %0d",
                     want.axis, want.position, out_ch.axis_out, out_ch.position_estimate);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("three_axis_alpha_beta_filter_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.axis   = '0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    alpha_q16    = '0;
    beta_q16     = '0;
    dt_q16       = abf_pkg::TSTEP_RESET;
    for (int i = 0; i < abf_pkg::AXES; i++) begin
      pos_est[i] = '0;
      vel_est[i] = '0;
    end
    send_idle_pct = 33;
    recv_idle_pct = 78;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_unit_gains();
    test_gains_above_one();
    test_zero_time_step();
    test_time_step_extremes();
    test_unknown_register();
    test_random_tracking();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && position_expect_q.size() == 0) begin
      $display("three_axis_alpha_beta_filter_tb OK");
    end else begin
      $display("three_axis_alpha_beta_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/abf_pkg.sv
hw/rtl/abf_in_if.sv
hw/rtl/abf_out_if.sv
hw/rtl/abf_cfg_if.sv
hw/rtl/abf_dp.sv
hw/rtl/three_axis_alpha_beta_filter.sv
dv/three_axis_alpha_beta_filter_tb.sv
